[src/csu_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, sequencer states and datapath control types for the cosine similarity unit.
package csu_pkg;

  localparam int COUNT_W      = 16;
  localparam int COUNT_BITS   = 16;
  localparam int MAX_ELEMENTS = 32;
  localparam int ELEM_CNT_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int SUM_W        = 40;
  localparam int PROD_W       = 2 * COUNT_BITS;
  localparam int FRAC_SHIFT   = 32;
  localparam int NN_W         = 2 * SUM_W;
  localparam int ROOT_W       = (NN_W + FRAC_SHIFT) / 2;
  localparam int REM_W        = ROOT_W + 2;
  localparam int NUM_W        = SUM_W + FRAC_SHIFT;
  localparam int SIM_W        = 17;
  localparam int ALU_W        = NN_W;
  localparam int PMUL_STEPS   = SUM_W;
  localparam int SQRT_STEPS   = ROOT_W;
  localparam int DIV_STEPS    = SIM_W;
  localparam int ITER_W       = $clog2(SQRT_STEPS);

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [SIM_W-1:0] SIM_ONE = {1'b1, {(SIM_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_AA,
    ST_MUL_BB,
    ST_ADD_BB,
    ST_CHECK,
    ST_PMUL,
    ST_SQRT,
    ST_DIV_CHECK,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE,
    DP_MUL_AB,
    DP_MUL_AA,
    DP_MUL_BB,
    DP_ADD_BB,
    DP_CHECK,
    DP_PMUL,
    DP_SQRT,
    DP_DIV_CHECK,
    DP_DIV,
    DP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } csu_ctrl_t;

  typedef struct packed {
    logic norm_zero;
    logic alu_carry;
  } csu_status_t;

endpackage

[src/csu_datapath.sv]
`timescale 1ns / 1ps
// Accumulators, one 16x16 multiplier and one shared 80-bit add/subtract unit.
module csu_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  csu_pkg::csu_ctrl_t             ctrl,
  input  logic [csu_pkg::COUNT_W-1:0]    count_a,
  input  logic [csu_pkg::COUNT_W-1:0]    count_b,
  output csu_pkg::csu_status_t           status,
  output logic [csu_pkg::SIM_W-1:0]      similarity
);

  logic [csu_pkg::COUNT_BITS-1:0] a_reg;
  logic [csu_pkg::COUNT_BITS-1:0] b_reg;
  logic [csu_pkg::COUNT_BITS-1:0] mul_x;
  logic [csu_pkg::COUNT_BITS-1:0] mul_y;
  logic [csu_pkg::PROD_W-1:0]     prod;
  logic [csu_pkg::SUM_W-1:0]      dot_sum;
  logic [csu_pkg::SUM_W-1:0]      norm_a_sum;
  logic [csu_pkg::SUM_W-1:0]      norm_b_sum;
  logic [csu_pkg::SUM_W-1:0]      sat_sum;
  logic [csu_pkg::NN_W-1:0]       acc;
  logic [csu_pkg::NUM_W-1:0]      rem;
  logic [csu_pkg::ROOT_W-1:0]     root;
  logic [csu_pkg::SIM_W-1:0]      quot;
  logic [csu_pkg::ALU_W-1:0]      alu_x;
  logic [csu_pkg::ALU_W-1:0]      alu_y;
  logic                           alu_sub;
  logic [csu_pkg::ALU_W:0]        alu_sum;
  logic                           alu_carry;

  // Operand selection for the single shared adder; subtraction is x + ~y + 1,
  // so the carry out means x >= y.
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    case (ctrl.op)
      csu_pkg::DP_MUL_AA: begin
        alu_x = csu_pkg::ALU_W'(dot_sum);
        alu_y = csu_pkg::ALU_W'(prod);
      end
      csu_pkg::DP_MUL_BB: begin
        alu_x = csu_pkg::ALU_W'(norm_a_sum);
        alu_y = csu_pkg::ALU_W'(prod);
      end
      csu_pkg::DP_ADD_BB: begin
        alu_x = csu_pkg::ALU_W'(norm_b_sum);
        alu_y = csu_pkg::ALU_W'(prod);
      end
      csu_pkg::DP_PMUL: begin
        alu_x = csu_pkg::ALU_W'({acc[csu_pkg::NN_W-2:0], 1'b0});
        alu_y = norm_b_sum[csu_pkg::SUM_W-1] ? csu_pkg::ALU_W'(norm_a_sum) : '0;
      end
      csu_pkg::DP_SQRT: begin
        alu_x   = csu_pkg::ALU_W'({rem[csu_pkg::REM_W-1:0], acc[csu_pkg::NN_W-1 -: 2]});
        alu_y   = csu_pkg::ALU_W'({root, 2'b01});
        alu_sub = 1'b1;
      end
      csu_pkg::DP_DIV_CHECK: begin
        alu_x   = csu_pkg::ALU_W'({dot_sum, {csu_pkg::FRAC_SHIFT{1'b0}}});
        alu_y   = csu_pkg::ALU_W'({root, {csu_pkg::SIM_W{1'b0}}});
        alu_sub = 1'b1;
      end
      csu_pkg::DP_DIV: begin
        alu_x   = csu_pkg::ALU_W'(rem);
        alu_y   = acc;
        alu_sub = 1'b1;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  assign alu_sum   = {1'b0, alu_x} + {1'b0, alu_y ^ {csu_pkg::ALU_W{alu_sub}}}
                     + (csu_pkg::ALU_W + 1)'(alu_sub);
  assign alu_carry = alu_sum[csu_pkg::ALU_W];
  assign sat_sum   = alu_sum[csu_pkg::SUM_W] ? csu_pkg::SUM_MAX
                                             : alu_sum[csu_pkg::SUM_W-1:0];

  always_comb begin
    mul_x = a_reg;
    mul_y = b_reg;
    case (ctrl.op)
      csu_pkg::DP_MUL_AB: begin
        mul_x = count_a[csu_pkg::COUNT_BITS-1:0];
        mul_y = count_b[csu_pkg::COUNT_BITS-1:0];
      end
      csu_pkg::DP_MUL_AA: begin
        mul_x = a_reg;
        mul_y = a_reg;
      end
      csu_pkg::DP_MUL_BB: begin
        mul_x = b_reg;
        mul_y = b_reg;
      end
      default: begin
        mul_x = a_reg;
      end
    endcase
  end

  // The sums are cleared by reset because every vector starts from zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum    <= '0;
      norm_a_sum <= '0;
      norm_b_sum <= '0;
    end else begin
      case (ctrl.op)
        csu_pkg::DP_MUL_AA: dot_sum    <= sat_sum;
        csu_pkg::DP_MUL_BB: norm_a_sum <= sat_sum;
        csu_pkg::DP_ADD_BB: norm_b_sum <= sat_sum;
        // The multiplier of na*nb is walked out of norm_b_sum from the top bit.
        csu_pkg::DP_PMUL: norm_b_sum <= {norm_b_sum[csu_pkg::SUM_W-2:0], 1'b0};
        csu_pkg::DP_CLEAR: begin
          dot_sum    <= '0;
          norm_a_sum <= '0;
          norm_b_sum <= '0;
        end
        default: begin
          dot_sum <= dot_sum;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      csu_pkg::DP_MUL_AB: begin
        a_reg <= count_a[csu_pkg::COUNT_BITS-1:0];
        b_reg <= count_b[csu_pkg::COUNT_BITS-1:0];
        prod  <= csu_pkg::PROD_W'(mul_x) * csu_pkg::PROD_W'(mul_y);
      end
      csu_pkg::DP_MUL_AA, csu_pkg::DP_MUL_BB: begin
        prod <= csu_pkg::PROD_W'(mul_x) * csu_pkg::PROD_W'(mul_y);
      end
      csu_pkg::DP_CHECK: begin
        acc  <= '0;
        rem  <= '0;
        root <= '0;
        quot <= '0;
      end
      csu_pkg::DP_PMUL: begin
        acc <= alu_sum[csu_pkg::NN_W-1:0];
      end
      // Two radicand bits per step leave the top of acc; zeros follow for the
      // fractional scaling.
      csu_pkg::DP_SQRT: begin
        acc  <= {acc[csu_pkg::NN_W-3:0], 2'b00};
        root <= {root[csu_pkg::ROOT_W-2:0], alu_carry};
        rem  <= alu_carry ? csu_pkg::NUM_W'(alu_sum[csu_pkg::REM_W-1:0])
                          : csu_pkg::NUM_W'(alu_x[csu_pkg::REM_W-1:0]);
      end
      csu_pkg::DP_DIV_CHECK: begin
        rem  <= {dot_sum, {csu_pkg::FRAC_SHIFT{1'b0}}};
        acc  <= csu_pkg::NN_W'({root, {(csu_pkg::SIM_W-1){1'b0}}});
        quot <= alu_carry ? csu_pkg::SIM_ONE : '0;
      end
      csu_pkg::DP_DIV: begin
        if (alu_carry) begin
          rem <= alu_sum[csu_pkg::NUM_W-1:0];
        end
        acc  <= {1'b0, acc[csu_pkg::NN_W-1:1]};
        quot <= {quot[csu_pkg::SIM_W-2:0], alu_carry};
      end
      default: begin
        prod <= prod;
      end
    endcase
  end

  assign status.norm_zero = (norm_a_sum == '0) || (norm_b_sum == '0);
  assign status.alu_carry = alu_carry;
  assign similarity       = (quot > csu_pkg::SIM_ONE) ? csu_pkg::SIM_ONE : quot;

endmodule

[src/cosine_similarity_unit.sv]
`timescale 1ns / 1ps
// Cosine similarity unit: sequencer, handshake and result register around the datapath.
// An item that is not the last makes three passes through one multiplier.
// A last item does the same, then, unless a norm is zero, a 40-step shift-add product of the norms,
// a 56-step square root and a 17-step division, all on one shared 80-bit adder.
// The result register lets the next item enter while a result waits to be taken.
// Synchronous reset clears the sums, element count, overflow flag and result valid.
module cosine_similarity_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        count_valid,
  output logic                        count_ready,
  input  logic [csu_pkg::COUNT_W-1:0] count_a,
  input  logic [csu_pkg::COUNT_W-1:0] count_b,
  input  logic                        last,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [csu_pkg::SIM_W-1:0]   similarity,
  output logic                        zero_norm,
  output logic                        too_long
);

  csu_pkg::state_t                 state, state_next;
  logic [csu_pkg::ITER_W-1:0]      iter, iter_next;
  logic [csu_pkg::ELEM_CNT_W-1:0]  elem_count, elem_count_next;
  logic                            overflow, overflow_next;
  logic                            last_reg, last_reg_next;
  logic                            zn, zn_next;
  logic                            result_valid_next;
  logic                            out_load;
  csu_pkg::csu_ctrl_t              ctrl;
  csu_pkg::csu_status_t            status;
  logic [csu_pkg::SIM_W-1:0]       dp_similarity;

  csu_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .count_a    (count_a),
    .count_b    (count_b),
    .status     (status),
    .similarity (dp_similarity)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= csu_pkg::ST_IDLE;
      iter         <= '0;
      elem_count   <= '0;
      overflow     <= 1'b0;
      last_reg     <= 1'b0;
      zn           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      iter         <= iter_next;
      elem_count   <= elem_count_next;
      overflow     <= overflow_next;
      last_reg     <= last_reg_next;
      zn           <= zn_next;
      result_valid <= result_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      similarity <= dp_similarity;
      zero_norm  <= zn;
      too_long   <= overflow;
    end
  end

  always_comb begin
    state_next        = state;
    iter_next         = iter;
    elem_count_next   = elem_count;
    overflow_next     = overflow;
    last_reg_next     = last_reg;
    zn_next           = zn;
    result_valid_next = result_valid && !result_ready;
    out_load          = 1'b0;
    ctrl.op           = csu_pkg::DP_NONE;
    count_ready       = 1'b0;
    case (state)
      csu_pkg::ST_IDLE: begin
        count_ready = 1'b1;
        if (count_valid) begin
          if (elem_count < csu_pkg::ELEM_CNT_W'(csu_pkg::MAX_ELEMENTS)) begin
            ctrl.op       = csu_pkg::DP_MUL_AB;
            last_reg_next = last;
            state_next    = csu_pkg::ST_MUL_AA;
          end else begin
            // An item beyond the limit is dropped but still closes the vector.
            overflow_next = 1'b1;
            if (last) begin
              state_next = csu_pkg::ST_CHECK;
            end
          end
        end
      end
      csu_pkg::ST_MUL_AA: begin
        ctrl.op    = csu_pkg::DP_MUL_AA;
        state_next = csu_pkg::ST_MUL_BB;
      end
      csu_pkg::ST_MUL_BB: begin
        ctrl.op    = csu_pkg::DP_MUL_BB;
        state_next = csu_pkg::ST_ADD_BB;
      end
      csu_pkg::ST_ADD_BB: begin
        ctrl.op         = csu_pkg::DP_ADD_BB;
        elem_count_next = elem_count + 1'b1;
        state_next      = last_reg ? csu_pkg::ST_CHECK : csu_pkg::ST_IDLE;
      end
      csu_pkg::ST_CHECK: begin
        ctrl.op = csu_pkg::DP_CHECK;
        zn_next = status.norm_zero;
        if (status.norm_zero) begin
          state_next = csu_pkg::ST_FINISH;
        end else begin
          iter_next  = csu_pkg::ITER_W'(csu_pkg::PMUL_STEPS - 1);
          state_next = csu_pkg::ST_PMUL;
        end
      end
      csu_pkg::ST_PMUL: begin
        ctrl.op   = csu_pkg::DP_PMUL;
        iter_next = iter - 1'b1;
        if (iter == '0) begin
          iter_next  = csu_pkg::ITER_W'(csu_pkg::SQRT_STEPS - 1);
          state_next = csu_pkg::ST_SQRT;
        end
      end
      csu_pkg::ST_SQRT: begin
        ctrl.op   = csu_pkg::DP_SQRT;
        iter_next = iter - 1'b1;
        if (iter == '0) begin
          state_next = csu_pkg::ST_DIV_CHECK;
        end
      end
      csu_pkg::ST_DIV_CHECK: begin
        ctrl.op = csu_pkg::DP_DIV_CHECK;
        // A quotient of two or more saturates at once to exactly one.
        if (status.alu_carry) begin
          state_next = csu_pkg::ST_FINISH;
        end else begin
          iter_next  = csu_pkg::ITER_W'(csu_pkg::DIV_STEPS - 1);
          state_next = csu_pkg::ST_DIV;
        end
      end
      csu_pkg::ST_DIV: begin
        ctrl.op   = csu_pkg::DP_DIV;
        iter_next = iter - 1'b1;
        if (iter == '0) begin
          state_next = csu_pkg::ST_FINISH;
        end
      end
      csu_pkg::ST_FINISH: begin
        if (!result_valid || result_ready) begin
          out_load          = 1'b1;
          result_valid_next = 1'b1;
          ctrl.op           = csu_pkg::DP_CLEAR;
          elem_count_next   = '0;
          overflow_next     = 1'b0;
          state_next        = csu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = csu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[src/csu_assert.sv]
`timescale 1ns / 1ps
// Port-level checker for the cosine similarity unit and its bind to the top level.
module csu_assert (
  input logic                        clk,
  input logic                        rst,
  input logic                        count_valid,
  input logic                        count_ready,
  input logic [csu_pkg::COUNT_W-1:0] count_a,
  input logic [csu_pkg::COUNT_W-1:0] count_b,
  input logic                        last,
  input logic                        result_valid,
  input logic                        result_ready,
  input logic [csu_pkg::SIM_W-1:0]   similarity,
  input logic                        zero_norm,
  input logic                        too_long
);

  // A waiting result keeps its fields until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(similarity) && $stable(zero_norm) && $stable(too_long))
    else $error("result changed while stalled");

  // An all-zero vector always reports a similarity of zero.
  a_zero_norm: assert property (@(posedge clk) disable iff (rst)
    result_valid && zero_norm |-> similarity == '0)
    else $error("zero norm with nonzero similarity");

  a_sim_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> similarity <= csu_pkg::SIM_ONE)
    else $error("similarity above one");

  // A new result is only produced from the final stage, where no item is taken.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(count_ready))
    else $error("result appeared while the input side was open");

endmodule

bind cosine_similarity_unit csu_assert u_csu_assert (.*);
